// File: sv/grc_pkg.sv
// Shared constants and types for the gyro rate conditioner.
`timescale 1ns / 1ps

package grc_pkg;

    // Default number of calibration samples per run
    localparam int CAL_SAMPLES_DEF = 32;

    // Stream widths
    localparam int S_DATA_W = 128;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 1;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_TYPE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_VALID = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MID_LR      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MID_FB      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MID_DU      = 3'd4;

    // Input item kind
    localparam logic KIND_CAL = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    // Rate scaling by sensor type
    typedef enum logic [2:0] {
        ST_NEG_DOUBLE = 3'd0,  // roll -2x, pitch 2x, yaw /2
        ST_HALF_YAW   = 3'd1,  // yaw /2
        ST_HALF_A     = 3'd2,  // roll, pitch /2, yaw /4
        ST_HALF_B     = 3'd3,  // same as ST_HALF_A
        ST_DIGITAL    = 3'd4,  // roll, pitch /256, yaw /512
        ST_NONE       = 3'd5,  // all rates zero
        ST_QUARTER    = 3'd6,  // roll, pitch /4, yaw /8
        ST_RAW        = 3'd7   // unscaled
    } sensor_type_t;

    // Accelerometer and drift correction constants
    localparam logic signed [15:0] ONE_G       = 16'sd1024;
    localparam logic signed [19:0] GRAV_MUL    = 20'sd11;
    localparam int                 GRAV_SHIFT  = 5;
    localparam int                 CORR_SHIFT  = 3;
    localparam logic signed [14:0] CORR_LIM    = 15'sd3;

endpackage

// File: sv/gyro_rate_conditioner.sv
// Gyro rate conditioner top level: calibration, rate scaling and drift correction.
`timescale 1ns / 1ps

// Conditions three-axis gyro samples, one result item per input item. An input
// item moves through an input register and then through the arithmetic into
// the result register, so a new item is taken every cycle unless the m_ side
// applies backpressure or the neutrals are being divided. Calibration items
// (tuser = 0) add the raw gyro readings into per-axis sums; the CAL_SAMPLES-th
// one divides the sums into the new neutrals, adding twice mid_lr and mid_fb to
// the roll and pitch sums when the accelerometer is off. That division runs in
// the cycle after the completing item leaves the input register (a constant
// reciprocal multiply) and holds the next item in the input register while it
// runs. Run items (tuser = 1) subtract the neutrals, scale by sensor_type and,
// with accel_valid set, also give offset-corrected accelerations and roll/pitch
// drift corrections in -3..3. Write configuration only while the block idles.
module gyro_rate_conditioner #(
    parameter int CAL_SAMPLES = grc_pkg::CAL_SAMPLES_DEF   // 2..256
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // gyro_roll, gyro_pitch, gyro_yaw, accel_lr, accel_fb, accel_du,
    // angle_roll, angle_pitch (16 bits each, from bit 0 up)
    input  logic [grc_pkg::S_DATA_W-1:0]    s_tdata,
    // kind
    input  logic [grc_pkg::S_USER_W-1:0]    s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rate_roll, rate_pitch, rate_yaw (16 each), corr_roll, corr_pitch (3 each),
    // acc_lr_out, acc_fb_out, acc_du_out (16 each), 2 zero pad bits
    output logic [grc_pkg::M_DATA_W-1:0]    m_tdata,
    // calibrated
    output logic [grc_pkg::M_USER_W-1:0]    m_tuser,

    input  logic                            cfg_wen,
    input  logic [grc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [grc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Sum width covers CAL_SAMPLES full-scale samples plus twice an 8-bit mid
    localparam int CNT_W  = $clog2(CAL_SAMPLES);
    localparam int SUM_W  = 17 + $clog2(CAL_SAMPLES);
    // Round-up reciprocal: exact floor(n / CAL_SAMPLES) for n < 2**SUM_W
    localparam int DIV_K  = SUM_W + $clog2(CAL_SAMPLES);
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_K) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int M_W    = SUM_W + 1;
    localparam int PROD_W = SUM_W + M_W;
    localparam logic [M_W-1:0]   DIV_M_C  = M_W'(DIV_M);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

    // Configuration
    grc_pkg::sensor_type_t  sens_type_reg;
    logic                   accel_valid_reg;
    logic signed [7:0]      mid_lr_reg;
    logic signed [7:0]      mid_fb_reg;
    logic signed [7:0]      mid_du_reg;

    // Input register and result register
    logic                           in_valid_reg;
    logic [grc_pkg::S_DATA_W-1:0]   in_tdata_reg;
    logic                           in_kind_reg;
    logic                           out_valid_reg;
    logic [grc_pkg::M_DATA_W-1:0]   out_tdata_reg;
    logic                           out_cal_reg;

    // Calibration state
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [15:0]       neut_reg [3];
    logic                     div_pend_reg;
    logic [SUM_W-1:0]         div_mag_reg [3];
    logic                     div_neg_reg [3];

    logic adv;
    logic cal_last;

    logic signed [15:0]       gyro [3];
    logic signed [SUM_W-1:0]  sum_next [3];
    logic signed [SUM_W-1:0]  total [3];
    logic [SUM_W-1:0]         mag [3];
    logic signed [15:0]       neut_next [3];
    logic [PROD_W-1:0]        prod [3];

    logic signed [15:0] d_ro, d_pi, d_ya;
    logic signed [15:0] ro, pi, ya;
    logic signed [15:0] acc_lr, acc_fb, acc_du;
    logic signed [2:0]  c_ro, c_pi;
    logic [grc_pkg::M_DATA_W-1:0] out_tdata_next;
    logic                         out_cal_next;

    // Drift correction for one axis: (acc - ((angle * 11) >> 5) + rate) >> 3,
    // clamped to -3..3
    function automatic logic signed [2:0] drift_corr(
        input logic signed [15:0] acc,
        input logic signed [15:0] angle,
        input logic signed [15:0] rate
    );
        logic signed [19:0] scaled;
        logic signed [19:0] shifted;
        logic signed [15:0] grav;
        logic signed [17:0] tot;
        logic signed [14:0] sh;
        logic signed [2:0]  res;
        scaled  = 20'(angle) * grc_pkg::GRAV_MUL;
        shifted = scaled >>> grc_pkg::GRAV_SHIFT;
        grav    = 16'(-shifted);
        tot     = 18'(acc) + 18'(grav) + 18'(rate);
        sh      = 15'(tot >>> grc_pkg::CORR_SHIFT);
        if (sh > grc_pkg::CORR_LIM) begin
            res = 3'(grc_pkg::CORR_LIM);
        end else if (sh < -grc_pkg::CORR_LIM) begin
            res = 3'(-grc_pkg::CORR_LIM);
        end else begin
            res = sh[2:0];
        end
        return res;
    endfunction

    // Advance the input register into the result register when the result register
    // is free or being taken, unless the neutrals are being divided out this cycle
    assign adv      = in_valid_reg && !div_pend_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign cal_last = (cnt_reg == CNT_LAST);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_cal_reg;

    // Calibration sums and the closing divide
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            gyro[i]     = in_tdata_reg[16*i +: 16];
            sum_next[i] = sum_reg[i] + SUM_W'(gyro[i]);
            total[i]    = sum_next[i];
        end
        if (!accel_valid_reg) begin
            total[0] = sum_next[0] + ({{(SUM_W-8){mid_lr_reg[7]}}, mid_lr_reg} <<< 1);
            total[1] = sum_next[1] + ({{(SUM_W-8){mid_fb_reg[7]}}, mid_fb_reg} <<< 1);
        end
        for (int i = 0; i < 3; i++) begin
            mag[i]       = total[i][SUM_W-1] ? SUM_W'(-total[i]) : SUM_W'(total[i]);
            prod[i]      = PROD_W'(div_mag_reg[i]) * PROD_W'(DIV_M_C);
            neut_next[i] = div_neg_reg[i] ? -$signed(prod[i][DIV_K +: 16])
                                          : $signed(prod[i][DIV_K +: 16]);
        end
    end

    // Run path: subtract neutrals, scale, then accelerometer terms
    always_comb begin
        d_ro = gyro[0] - neut_reg[0];
        d_pi = gyro[1] - neut_reg[1];
        d_ya = gyro[2] - neut_reg[2];
        ro   = d_ro;
        pi   = d_pi;
        ya   = d_ya;
        unique case (sens_type_reg) inside
            grc_pkg::ST_NEG_DOUBLE: begin
                ro = -(d_ro <<< 1);
                pi = d_pi <<< 1;
                ya = d_ya >>> 1;
            end
            grc_pkg::ST_HALF_YAW: begin
                ya = d_ya >>> 1;
            end
            grc_pkg::ST_HALF_A, grc_pkg::ST_HALF_B: begin
                ro = d_ro >>> 1;
                pi = d_pi >>> 1;
                ya = d_ya >>> 2;
            end
            grc_pkg::ST_DIGITAL: begin
                ro = d_ro >>> 8;
                pi = d_pi >>> 8;
                ya = d_ya >>> 9;
            end
            grc_pkg::ST_NONE: begin
                ro = '0;
                pi = '0;
                ya = '0;
            end
            grc_pkg::ST_QUARTER: begin
                ro = d_ro >>> 2;
                pi = d_pi >>> 2;
                ya = d_ya >>> 3;
            end
            grc_pkg::ST_RAW: begin
            end
            default: begin
            end
        endcase

        acc_lr = $signed(in_tdata_reg[63:48]) - 16'(mid_lr_reg);
        acc_fb = $signed(in_tdata_reg[79:64]) - 16'(mid_fb_reg);
        acc_du = $signed(in_tdata_reg[95:80]) - 16'(mid_du_reg) - grc_pkg::ONE_G;
        c_ro   = drift_corr(acc_lr, $signed(in_tdata_reg[111:96]), ro);
        c_pi   = drift_corr(acc_fb, $signed(in_tdata_reg[127:112]), pi);

        out_tdata_next = '0;
        out_cal_next   = 1'b0;
        if (in_kind_reg == grc_pkg::KIND_RUN) begin
            if (accel_valid_reg) begin
                out_tdata_next = {2'b00, acc_du, acc_fb, acc_lr, c_pi, c_ro, ya, pi, ro};
            end else begin
                out_tdata_next[47:0] = {ya, pi, ro};
            end
        end else begin
            out_cal_next = cal_last;
        end
    end

    // Control, configuration and calibration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_type_reg   <= grc_pkg::ST_RAW;
            accel_valid_reg <= 1'b0;
            mid_lr_reg      <= '0;
            mid_fb_reg      <= '0;
            mid_du_reg      <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            div_pend_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]  <= '0;
                neut_reg[i] <= '0;
            end
        end else begin
            if (cfg_wen) begin
                unique case (cfg_addr)
                    grc_pkg::REG_SENSOR_TYPE:
                        sens_type_reg <= grc_pkg::sensor_type_t'(cfg_wdata[2:0]);
                    grc_pkg::REG_ACCEL_VALID: accel_valid_reg <= cfg_wdata[0];
                    grc_pkg::REG_MID_LR:      mid_lr_reg      <= $signed(cfg_wdata);
                    grc_pkg::REG_MID_FB:      mid_fb_reg      <= $signed(cfg_wdata);
                    grc_pkg::REG_MID_DU:      mid_du_reg      <= $signed(cfg_wdata);
                    default: begin
                    end
                endcase
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // Finish the divide: load the new neutrals
            if (div_pend_reg) begin
                div_pend_reg <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    neut_reg[i] <= neut_next[i];
                end
            end

            if (adv && in_kind_reg == grc_pkg::KIND_CAL) begin
                if (cal_last) begin
                    cnt_reg      <= '0;
                    div_pend_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        sum_reg[i] <= '0;
                    end
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        sum_reg[i] <= sum_next[i];
                    end
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_tdata_reg <= s_tdata;
            in_kind_reg  <= s_tuser[0];
        end
        if (adv) begin
            out_tdata_reg <= out_tdata_next;
            out_cal_reg   <= out_cal_next;
        end
        if (adv && in_kind_reg == grc_pkg::KIND_CAL && cal_last) begin
            for (int i = 0; i < 3; i++) begin
                div_mag_reg[i] <= mag[i];
                div_neg_reg[i] <= total[i][SUM_W-1];
            end
        end
    end

`ifndef SYNTHESIS
    // No item passes the arithmetic while the neutrals are being divided
    a_hold_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_pend_reg |-> !adv)
        else $error("item advanced during neutral divide");

    // A completing calibration item always starts the divide
    a_div_follows_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_kind_reg == grc_pkg::KIND_CAL && cal_last) |=> div_pend_reg)
        else $error("calibration completed without divide");

    // The sample count never passes the run length
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LAST)
        else $error("calibration count out of range");

    // A result marked calibrated carries no rates, corrections or accelerations
    a_cal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("calibration result with nonzero data");

    // Drift corrections stay within -3..3
    a_corr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50:48] != 3'b100 && m_tdata[53:51] != 3'b100))
        else $error("drift correction out of range");
`endif

endmodule

// File: bench/tb.sv
// Self-checking testbench for the gyro rate conditioner stream block.
`timescale 1ns / 1ps

module tb;
    import grc_pkg::*;

    // Calibration run length; matches the block's default parameter
    localparam int CAL_RUN        = 32;
    // Arithmetic of the drift correction and the 1g offset on the down-up axis
    localparam int GRAV_FACTOR    = 11;
    localparam int GRAV_SHR       = 5;
    localparam int CORR_SHR       = 3;
    localparam int CORR_MAX       = 3;
    localparam int ONE_G_COUNTS   = 1024;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

    // Run shape
    localparam int RESET_CYCLES   = 11;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 125;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_NS     = 4_000_000;

    // How the random fields of an item are drawn
    typedef enum int {
        V_WIDE,  // any 16-bit value
        V_EDGE,  // most negative, most positive, zero, minus one
        V_NEAR   // close to the current neutral or offset
    } value_mode_t;

    // One conditioned result, field by field
    typedef struct packed {
        logic [15:0] rate_roll;
        logic [15:0] rate_pitch;
        logic [15:0] rate_yaw;
        logic [2:0]  corr_roll;
        logic [2:0]  corr_pitch;
        logic [15:0] acc_lr;
        logic [15:0] acc_fb;
        logic [15:0] acc_du;
        logic        calibrated;
    } cond_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    wire                    s_tready;
    // gyro_roll, gyro_pitch, gyro_yaw, accel_lr, accel_fb, accel_du,
    // angle_roll, angle_pitch (16 bits each, from bit 0 up)
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    // kind
    logic [S_USER_W-1:0]    s_tuser   = '0;
    wire                    m_tvalid;
    logic                   m_tready  = 1'b0;
    // rate_roll, rate_pitch, rate_yaw (16 each), corr_roll, corr_pitch (3 each),
    // acc_lr_out, acc_fb_out, acc_du_out (16 each), 2 zero pad bits
    wire [M_DATA_W-1:0]     m_tdata;
    // calibrated
    wire [M_USER_W-1:0]     m_tuser;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Mirror of the conditioner: registers, calibration state and the queue
    // of conditioned results still owed by the block.
    class conditioner_scoreboard;
        sensor_type_t       sensor    = ST_RAW;
        bit                 accel_on  = 1'b0;
        longint             mid_lr    = 0;
        longint             mid_fb    = 0;
        longint             mid_du    = 0;
        longint             sums [3]  = '{0, 0, 0};
        int                 cal_count = 0;
        logic signed [15:0] neut [3]  = '{0, 0, 0};
        cond_result_t       conditioned_q [$];
        int                 errors    = 0;
        int                 results   = 0;

        function longint wrap16(longint v);
            logic signed [15:0] t;
            t = v[15:0];
            return t;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SENSOR_TYPE: sensor   = sensor_type_t'(val[2:0]);
                REG_ACCEL_VALID: accel_on = val[0];
                REG_MID_LR:      mid_lr   = longint'($signed(val));
                REG_MID_FB:      mid_fb   = longint'($signed(val));
                REG_MID_DU:      mid_du   = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function int cal_left();
            return CAL_RUN - cal_count;
        endfunction

        // Gravity-compensated drift step for one axis, clamped to +/-3
        function longint drift(longint acc, longint angle, longint rate);
            longint grav;
            longint c;
            grav = wrap16(-((angle * GRAV_FACTOR) >>> GRAV_SHR));
            c = (acc + grav + rate) >>> CORR_SHR;
            if (c > CORR_MAX)
                c = CORR_MAX;
            if (c < -CORR_MAX)
                c = -CORR_MAX;
            return c;
        endfunction

        // Work out the result of one accepted input item and queue it
        function void note_input(logic kind, logic [S_DATA_W-1:0] d);
            longint       f [8];
            longint       ro, pi, ya, lr, fb, du, c;
            cond_result_t e;
            int           i;
            for (i = 0; i < 8; i++)
                f[i] = wrap16(longint'(d[16*i +: 16]));
            e = '0;
            if (kind == KIND_CAL) begin
                for (i = 0; i < 3; i++)
                    sums[i] += f[i];
                cal_count++;
                if (cal_count >= CAL_RUN) begin
                    // without the accelerometer, fold twice the side offsets in
                    if (!accel_on) begin
                        sums[0] += 2 * mid_lr;
                        sums[1] += 2 * mid_fb;
                    end
                    for (i = 0; i < 3; i++) begin
                        neut[i] = sums[i] / CAL_RUN;  // truncates toward zero
                        sums[i] = 0;
                    end
                    cal_count    = 0;
                    e.calibrated = 1'b1;
                end
            end else begin
                ro = wrap16(f[0] - neut[0]);
                pi = wrap16(f[1] - neut[1]);
                ya = wrap16(f[2] - neut[2]);
                case (sensor)
                    ST_NEG_DOUBLE: begin
                        ro = wrap16(-2 * ro);
                        pi = wrap16(2 * pi);
                        ya = ya >>> 1;
                    end
                    ST_HALF_YAW: begin
                        ya = ya >>> 1;
                    end
                    ST_HALF_A, ST_HALF_B: begin
                        ro = ro >>> 1;
                        pi = pi >>> 1;
                        ya = ya >>> 2;
                    end
                    ST_DIGITAL: begin
                        ro = ro >>> 8;
                        pi = pi >>> 8;
                        ya = ya >>> 9;
                    end
                    ST_NONE: begin
                        ro = 0;
                        pi = 0;
                        ya = 0;
                    end
                    ST_QUARTER: begin
                        ro = ro >>> 2;
                        pi = pi >>> 2;
                        ya = ya >>> 3;
                    end
                    default: ;
                endcase
                e.rate_roll  = ro[15:0];
                e.rate_pitch = pi[15:0];
                e.rate_yaw   = ya[15:0];
                if (accel_on) begin
                    lr = wrap16(f[3] - mid_lr);
                    fb = wrap16(f[4] - mid_fb);
                    du = wrap16(f[5] - mid_du - ONE_G_COUNTS);
                    c = drift(lr, f[6], ro);
                    e.corr_roll = c[2:0];
                    c = drift(fb, f[7], pi);
                    e.corr_pitch = c[2:0];
                    e.acc_lr = lr[15:0];
                    e.acc_fb = fb[15:0];
                    e.acc_du = du[15:0];
                end
            end
            conditioned_q.push_back(e);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void compare(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                note_error($sformatf("result %0d %s: expected %h, got %h",
                                     results, what, want, got));
        endfunction

        // Compare one accepted result with the oldest queued one
        function void check_result(logic [M_DATA_W-1:0] d, logic calib);
            cond_result_t e;
            results++;
            if (conditioned_q.size() == 0) begin
                note_error($sformatf("result %0d arrived with nothing queued: %h/%b",
                                     results, d, calib));
                return;
            end
            e = conditioned_q.pop_front();
            compare("rate_roll",  e.rate_roll,  d[15:0]);
            compare("rate_pitch", e.rate_pitch, d[31:16]);
            compare("rate_yaw",   e.rate_yaw,   d[47:32]);
            compare("corr_roll",  e.corr_roll,  d[50:48]);
            compare("corr_pitch", e.corr_pitch, d[53:51]);
            compare("acc_lr_out", e.acc_lr,     d[69:54]);
            compare("acc_fb_out", e.acc_fb,     d[85:70]);
            compare("acc_du_out", e.acc_du,     d[101:86]);
            compare("pad bits",   16'h0,        d[103:102]);
            compare("calibrated", e.calibrated, calib);
        endfunction

        function void close_out();
            if (conditioned_q.size() != 0)
                note_error($sformatf("%0d results never arrived", conditioned_q.size()));
        endfunction
    endclass

    conditioner_scoreboard sb;
    int burst_left = 0;

    gyro_rate_conditioner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Check every result item taken on the m_ side
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    // Result side: stall on patterns of its own, and once hold off long
    // enough that the block backs up and drops s_tready.
    initial begin
        int  span;
        int  k;
        int  mode;
        bit  held;
        held = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && sb.results >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++)
                    @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(20, 150);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0: m_tready <= 1'b1;                          // no stalls
                        1: m_tready <= ($urandom_range(0, 2) != 0);   // scattered stalls
                        default: m_tready <= (k % 4 == 0);            // ready when k is a multiple of four
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Drop s_tvalid and let the bench idle
    task automatic idle(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Offer one item, wait for it to be taken, note it, then pace the bursts
    task automatic send_item(logic kind, logic [S_DATA_W-1:0] d);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= kind;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_input(kind, d);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle(gap);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(sensor_type_t st, bit av, logic [7:0] lr, logic [7:0] fb,
                             logic [7:0] du);
        write_reg(REG_SENSOR_TYPE, {5'b0, st});
        write_reg(REG_ACCEL_VALID, {7'b0, av});
        write_reg(REG_MID_LR, lr);
        write_reg(REG_MID_FB, fb);
        write_reg(REG_MID_DU, du);
    endtask

    // Hold off until every queued result is back, then let the block settle
    // before any register write.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.conditioned_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick16(value_mode_t mode);
        if (mode == V_EDGE) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (mode == V_NEAR)
            return 16'($urandom_range(0, 80) - 40);
        return 16'($urandom);
    endfunction

    function automatic value_mode_t any_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return V_WIDE;
        if (r < 6)
            return V_EDGE;
        return V_NEAR;
    endfunction

    // Draw the eight data fields of one item
    function automatic logic [S_DATA_W-1:0] make_fields(value_mode_t mode);
        logic [S_DATA_W-1:0] d;
        longint              base;
        int                  i;
        for (i = 0; i < 8; i++) begin
            if (mode == V_NEAR) begin
                // center on what the block subtracts, so rates and accels land near zero
                case (i)
                    0, 1, 2: base = sb.neut[i];
                    3:       base = sb.mid_lr;
                    4:       base = sb.mid_fb;
                    5:       base = sb.mid_du + ONE_G_COUNTS;
                    default: base = 0;
                endcase
                d[16*i +: 16] = 16'(base + longint'($urandom_range(0, 80)) - 40);
            end else begin
                d[16*i +: 16] = pick16(mode);
            end
        end
        return d;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_fields(longint gr, longint gp, longint gy,
            longint alr, longint afb, longint adu, longint angr, longint angp);
        return {16'(angp), 16'(angr), 16'(adu), 16'(afb), 16'(alr), 16'(gy), 16'(gp),
                16'(gr)};
    endfunction

    // Mostly complete calibration runs and run bursts; a little mixed noise
    task automatic run_phase(int quota);
        int                  sent;
        int                  n;
        int                  left;
        bit                  fixed;
        logic [S_DATA_W-1:0] fixed_d;
        sent = 0;
        while (sent < quota) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // finish the calibration run; sometimes every sample is the same,
                    // which can drive the sums to their extremes
                    left    = sb.cal_left();
                    fixed   = ($urandom_range(0, 3) == 0);
                    fixed_d = make_fields(fixed ? V_EDGE : any_mode());
                    while (left > 0) begin
                        if ($urandom_range(0, 5) == 0) begin
                            send_item(KIND_RUN, make_fields(any_mode()));
                        end else begin
                            send_item(KIND_CAL, fixed ? fixed_d : make_fields(any_mode()));
                            left--;
                        end
                        sent++;
                    end
                end
                9: begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        send_item(KIND_CAL, make_fields(V_WIDE));
                        send_item(KIND_RUN, make_fields(V_WIDE));
                        sent += 2;
                    end
                end
                default: begin
                    n = $urandom_range(3, 20);
                    repeat (n) begin
                        send_item(KIND_RUN, make_fields(any_mode()));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        int           p;
        int           n;
        sensor_type_t st;
        bit           av;
        logic [7:0]   lr, fb, du;

        sb = new;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset settings: unscaled rates, no accelerometer, zero neutrals
        send_item(KIND_RUN, {8{16'h0000}});
        send_item(KIND_RUN, {8{16'h7FFF}});
        send_item(KIND_RUN, {8{16'h8000}});
        // start a calibration run, then check a run item leaves it alone
        send_item(KIND_CAL, {8{16'h7FFF}});
        send_item(KIND_CAL, {8{16'h8000}});
        send_item(KIND_CAL, pack_fields(1000, -1000, 5, 0, 0, 0, 0, 0));
        send_item(KIND_RUN, make_fields(V_WIDE));
        settle();

        // Doubling with negation, accelerometer on, offsets at their extremes;
        // writes to unmapped indexes must change nothing
        configure(ST_NEG_DOUBLE, 1'b1, 8'h7F, 8'h80, 8'h7F);
        write_reg(REG_UNUSED_LO, 8'hFF);
        write_reg(REG_UNUSED_HI, 8'h55);
        send_item(KIND_RUN, {8{16'h7FFF}});
        send_item(KIND_RUN, {8{16'h8000}});
        send_item(KIND_RUN, pack_fields(0, 0, 0, 127, -128, 127 + ONE_G_COUNTS, 0, 0));
        // corrections pinned at the top and at the bottom of their range
        send_item(KIND_RUN, pack_fields(0, 0, 0, 32767, 32767, 0, -32768, -32768));
        send_item(KIND_RUN, pack_fields(0, 0, 0, -32768, -32768, 0, 32767, 32767));
        repeat (4) send_item(KIND_RUN, make_fields(V_NEAR));
        settle();

        configure(ST_DIGITAL, 1'b0, 8'h80, 8'h7F, 8'h80);
        send_item(KIND_RUN, {8{16'h7FFF}});
        send_item(KIND_RUN, {8{16'h8000}});

        // Random phases: walk every sensor type, toggle the accelerometer,
        // and put the offsets at their extremes every fourth phase
        for (p = 0; p < PHASES; p++) begin
            settle();
            st = (p < 8) ? sensor_type_t'(p) : sensor_type_t'($urandom_range(0, 7));
            av = (p % 3 != 1);
            if (p % 4 == 0) begin
                lr = (p % 8 == 0) ? 8'h7F : 8'h80;
                fb = ~lr;
                du = lr;
            end else begin
                lr = 8'($urandom);
                fb = 8'($urandom);
                du = 8'($urandom);
            end
            configure(st, av, lr, fb, du);
            run_phase(PHASE_ITEMS);
        end

        // Drain: wait for every queued result, then watch for strays
        s_tvalid <= 1'b0;
        n = 0;
        while (sb.conditioned_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.close_out();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/grc_pkg.sv
sv/gyro_rate_conditioner.sv
bench/tb.sv
